/* rtl/cas_pkg.sv */
package cas_pkg;

    // Block sizing
    localparam int CHANNELS      = 8;
    localparam int FRACTION_BITS = 8;

    // Fixed field widths
    localparam int ChanW        = 3;
    localparam int CodeW        = 16;
    localparam int CodeBits     = 12;
    localparam int AngleW       = CodeBits + FRACTION_BITS;
    localparam int GainW        = 17;
    localparam int GainFracBits = 16;
    localparam int IdxW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ProdW        = AngleW + GainW;

    localparam logic [CodeW-1:0] CodeMax   = CodeW'((1 << CodeBits) - 1);
    localparam logic [GainW-1:0] GainOne   = GainW'(1 << GainFracBits);
    localparam logic [GainW-1:0] GainReset = GainW'(6554);

    typedef logic [ChanW-1:0]  chan_t;
    typedef logic [CodeW-1:0]  code_t;
    typedef logic [AngleW-1:0] angle_t;
    typedef logic [GainW-1:0]  gain_t;
    typedef logic [IdxW-1:0]   idx_t;

    // Write request into the per-channel angle store
    typedef struct packed {
        logic   we;
        idx_t   idx;
        angle_t angle;
    } store_wr_t;

    function automatic idx_t chan_index(input chan_t ch);
        return IdxW'(ch);
    endfunction

    function automatic logic chan_in_range(input chan_t ch);
        return (32'(ch) < 32'(CHANNELS));
    endfunction

endpackage

/* rtl/cas_store.sv */
module cas_store (
    input  logic              clk,
    input  logic              rst_n,
    input  cas_pkg::idx_t     rd_idx,
    output cas_pkg::angle_t   rd_angle,
    output logic              rd_seeded,
    input  cas_pkg::store_wr_t wr
);
    import cas_pkg::*;

    angle_t angle_reg  [CHANNELS];
    logic   seeded_reg [CHANNELS];

    assign rd_angle  = angle_reg[rd_idx];
    assign rd_seeded = seeded_reg[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                angle_reg[i]  <= '0;
                seeded_reg[i] <= 1'b0;
            end
        end
        else if (wr.we)
        begin
            angle_reg[wr.idx]  <= wr.angle;
            seeded_reg[wr.idx] <= 1'b1;
        end
    end

    // A written channel is seeded and holds the written angle
    a_write_seeds: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |=> seeded_reg[$past(wr.idx)])
        else $error("written channel not marked seeded");

    a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |=> angle_reg[$past(wr.idx)] == $past(wr.angle))
        else $error("written angle not stored");

endmodule

/* rtl/cas_update.sv */
module cas_update (
    input  cas_pkg::chan_t     channel,
    input  cas_pkg::code_t     raw_code,
    input  cas_pkg::gain_t     gain,
    input  cas_pkg::angle_t    stored,
    input  logic               seeded,
    output cas_pkg::angle_t    angle_new,
    output logic               fault,
    output cas_pkg::store_wr_t wr
);
    import cas_pkg::*;

    localparam logic signed [AngleW:0] HalfTurn = (AngleW+1)'(1 << (AngleW - 1));
    localparam logic signed [AngleW:0] Turn     = (AngleW+1)'(1 << AngleW);
    localparam logic [ProdW:0]         RoundBit = (ProdW+1)'(1 << (GainFracBits - 1));

    logic                     in_range;
    logic                     bad_code;
    gain_t                    gain_eff;
    angle_t                   fresh;
    logic signed [AngleW:0]   diff;
    logic signed [AngleW:0]   delta;
    logic                     neg;
    logic [AngleW:0]          mag_wide;
    angle_t                   mag;
    logic [ProdW-1:0]         prod;
    logic [ProdW:0]           rounded;
    angle_t                   step;
    angle_t                   smoothed;

    assign in_range = chan_in_range(channel);
    assign bad_code = (raw_code > CodeMax);
    assign gain_eff = (gain > GainOne) ? GainOne : gain;
    assign fresh    = AngleW'(raw_code[CodeBits-1:0]) << FRACTION_BITS;

    // Shortest path, an exact half turn keeps its sign
    always_comb
    begin
        diff = $signed({1'b0, fresh}) - $signed({1'b0, stored});
        if (diff > HalfTurn)
            delta = diff - Turn;
        else if (diff < -HalfTurn)
            delta = diff + Turn;
        else
            delta = diff;
    end

    assign neg      = delta[AngleW];
    assign mag_wide = neg ? (AngleW+1)'(-delta) : (AngleW+1)'(delta);
    assign mag      = mag_wide[AngleW-1:0];
    assign prod     = ProdW'(mag) * ProdW'(gain_eff);
    assign rounded  = {1'b0, prod} + RoundBit;
    assign step     = AngleW'(rounded >> GainFracBits);
    assign smoothed = neg ? (stored - step) : (stored + step);

    always_comb
    begin
        wr.idx   = chan_index(channel);
        wr.angle = seeded ? smoothed : fresh;
        wr.we    = in_range && !bad_code;
        if (!in_range)
        begin
            angle_new = '0;
            fault     = 1'b1;
        end
        else if (bad_code)
        begin
            angle_new = stored;
            fault     = 1'b1;
        end
        else
        begin
            angle_new = wr.angle;
            fault     = 1'b0;
        end
    end

endmodule

/* rtl/circular_angle_smoothing_filter.sv */
// Circular angle smoothing filter. Each request carries a channel and a raw
// 16-bit angle code; each produces exactly one result with the channel, the
// channel's filtered angle (units of 2^-20 turn) and a fault bit. A code above
// 4095 sets fault and returns the stored angle untouched; the first good code
// on a channel loads the angle directly, later ones move it by gain times the
// shortest-path difference (rounded, ties away from zero) and wrap on one turn.
// Throughput is one request per clock while the result side does not stall.
// The input register loads at acceptance and the result register once the
// result slot is free or being taken; result_valid then holds the result
// until it is taken. The per-channel angle store is read, updated through
// one 20x17 multiply and written back as the request moves from the input
// register to the result register, so back-to-back requests on the same
// channel see each other's updates. cfg_we writes the Q1.16 gain (65536 is
// one, larger values act as one); change it only while idle.
module circular_angle_smoothing_filter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cas_pkg::gain_t        cfg_wdata,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  cas_pkg::chan_t        channel,
    input  cas_pkg::code_t        raw_code,
    output logic                  result_valid,
    input  logic                  result_stall,
    output cas_pkg::chan_t        channel_out,
    output cas_pkg::angle_t       angle_out,
    output logic                  fault
);
    import cas_pkg::*;

    gain_t     gain_reg;

    // Input stage
    logic      stage_valid_reg, stage_valid_next;
    chan_t     stage_channel_reg;
    code_t     stage_code_reg;

    // Result stage
    logic      result_valid_reg, result_valid_next;
    chan_t     result_channel_reg;
    angle_t    result_angle_reg;
    logic      result_fault_reg;

    logic      stage_load;
    logic      result_load;

    angle_t    rd_angle;
    logic      rd_seeded;
    angle_t    upd_angle;
    logic      upd_fault;
    store_wr_t upd_wr;
    store_wr_t store_wr;

    // Handshake: advance the input stage whenever the result slot frees up
    assign result_load  = stage_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = stage_valid_reg && !result_load;
    assign stage_load   = sample_valid && !sample_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (stage_load)
            stage_valid_next = 1'b1;
        else if (result_load)
            stage_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (result_load)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg         <= GainReset;
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                gain_reg <= cfg_wdata;
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers: hold unless loaded
    always_ff @(posedge clk)
    begin
        if (stage_load)
        begin
            stage_channel_reg <= channel;
            stage_code_reg    <= raw_code;
        end
        if (result_load)
        begin
            result_channel_reg <= stage_channel_reg;
            result_angle_reg   <= upd_angle;
            result_fault_reg   <= upd_fault;
        end
    end

    cas_update u_update (
        .channel   (stage_channel_reg),
        .raw_code  (stage_code_reg),
        .gain      (gain_reg),
        .stored    (rd_angle),
        .seeded    (rd_seeded),
        .angle_new (upd_angle),
        .fault     (upd_fault),
        .wr        (upd_wr)
    );

    // Commit the store write only when the request moves into the result slot
    always_comb
    begin
        store_wr    = upd_wr;
        store_wr.we = upd_wr.we && result_load;
    end

    cas_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_idx    (chan_index(stage_channel_reg)),
        .rd_angle  (rd_angle),
        .rd_seeded (rd_seeded),
        .wr        (store_wr)
    );

    assign result_valid = result_valid_reg;
    assign channel_out  = result_channel_reg;
    assign angle_out    = result_angle_reg;
    assign fault        = result_fault_reg;

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid_reg |-> !sample_stall)
        else $error("request stalled with empty input stage");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> result_valid_reg)
        else $error("advanced request produced no result");

    a_range_fault: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !chan_in_range(result_channel_reg) |->
            result_fault_reg && (result_angle_reg == '0))
        else $error("out-of-range channel without fault");

    a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        result_load && upd_fault |-> !store_wr.we)
        else $error("faulted request wrote the store");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    import cas_pkg::*;

    // Run limits. The slowest correct run is a few hundred requests, each
    // waiting out random sender gaps and result stalls, plus the idle waits
    // before each gain change. Allow far more.
    localparam int     CycleLimit = 400000;
    localparam int     IdlePct    = 36;
    localparam int     DrainTail  = 8;
    localparam longint FullTurn   = longint'(1) << AngleW;
    localparam longint HalfTurn   = FullTurn / 2;

    // Directed script rows: either a gain write or one sample request.
    typedef enum logic [0:0] {
        ROW_GAIN,
        ROW_READ
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  chan;
        logic [31:0] value;     // gain for ROW_GAIN, raw code for ROW_READ
        logic        typed;     // expected result written out below
        logic [19:0] exp_angle;
        logic        exp_fault;
    } script_row_t;

    // One result as the block reports it.
    typedef struct packed {
        chan_t  chan;
        angle_t angle;
        logic   fault;
    } filtered_reading_t;

    // Directed part. Typed expectations only where the answer is obvious:
    // reads on untouched channels, first loads, failures, unit and zero gain.
    script_row_t script [25] = '{
        // failing read right after reset returns the zero angle
        '{ROW_READ, 3'd0, 32'h0000_FFFF, 1'b1, 20'h00000, 1'b1},
        // just above the valid code range
        '{ROW_READ, 3'd0, 32'h0000_1000, 1'b1, 20'h00000, 1'b1},
        // first good code loads the angle directly
        '{ROW_READ, 3'd0, 32'h0000_0000, 1'b1, 20'h00000, 1'b0},
        '{ROW_READ, 3'd1, 32'h0000_0FFF, 1'b1, 20'hFFF00, 1'b0},
        // failure on a seeded channel keeps its angle
        '{ROW_READ, 3'd1, 32'h0000_8000, 1'b1, 20'hFFF00, 1'b1},
        // shortest path across zero, reset gain
        '{ROW_READ, 3'd1, 32'h0000_0000, 1'b0, 20'h00000, 1'b0},
        '{ROW_READ, 3'd2, 32'h0000_0800, 1'b1, 20'h80000, 1'b0},
        // unit gain: stored angle follows the code exactly
        '{ROW_GAIN, 3'd0, 32'd65536,     1'b0, 20'h00000, 1'b0},
        // exactly minus a half turn, then exactly plus a half turn
        '{ROW_READ, 3'd2, 32'h0000_0000, 1'b1, 20'h00000, 1'b0},
        '{ROW_READ, 3'd2, 32'h0000_0800, 1'b1, 20'h80000, 1'b0},
        '{ROW_READ, 3'd3, 32'h0000_0064, 1'b1, 20'h06400, 1'b0},
        // gain above one acts as one
        '{ROW_GAIN, 3'd0, 32'd131071,    1'b0, 20'h00000, 1'b0},
        '{ROW_READ, 3'd3, 32'h0000_0FA0, 1'b1, 20'hFA000, 1'b0},
        '{ROW_READ, 3'd3, 32'h0000_FFFF, 1'b1, 20'hFA000, 1'b1},
        // zero gain freezes the angle but still clears the fault
        '{ROW_GAIN, 3'd0, 32'd0,         1'b0, 20'h00000, 1'b0},
        '{ROW_READ, 3'd3, 32'h0000_0005, 1'b1, 20'hFA000, 1'b0},
        '{ROW_READ, 3'd4, 32'h0000_04D2, 1'b1, 20'h4D200, 1'b0},
        // half gain: the stored angle moves half way toward each code
        '{ROW_GAIN, 3'd0, 32'd32768,     1'b0, 20'h00000, 1'b0},
        '{ROW_READ, 3'd4, 32'h0000_04D3, 1'b0, 20'h00000, 1'b0},
        '{ROW_READ, 3'd4, 32'h0000_0BB8, 1'b0, 20'h00000, 1'b0},
        // failures on a channel never seeded
        '{ROW_READ, 3'd5, 32'h0000_AAAA, 1'b1, 20'h00000, 1'b1},
        '{ROW_READ, 3'd5, 32'h0000_5555, 1'b1, 20'h00000, 1'b1},
        '{ROW_READ, 3'd7, 32'h0000_0FFF, 1'b1, 20'hFFF00, 1'b0},
        '{ROW_GAIN, 3'd0, 32'd6554,      1'b0, 20'h00000, 1'b0},
        '{ROW_READ, 3'd6, 32'h0000_0001, 1'b1, 20'h00100, 1'b0}
    };

    // DUT ports; the driven inputs are all known from time zero.
    logic   clk          = 1'b0;
    logic   rst_n        = 1'b0;
    logic   cfg_we       = 1'b0;
    gain_t  cfg_wdata    = '0;
    logic   sample_valid = 1'b0;
    logic   sample_stall;
    chan_t  channel      = '0;
    code_t  raw_code     = '0;
    logic   result_valid;
    logic   result_stall = 1'b0;
    chan_t  channel_out;
    angle_t angle_out;
    logic   fault;

    // Predictor state: its own copy of the per-channel filter and the gain.
    angle_t model_angle  [CHANNELS];
    logic   model_seeded [CHANNELS];
    logic   model_fault  [CHANNELS];
    gain_t  model_gain;

    // Results still owed by the block, oldest first.
    filtered_reading_t pending_readings [$];

    // Typed expectation riding along with the request being driven.
    logic   row_typed = 1'b0;
    angle_t row_angle = '0;
    logic   row_fault = 1'b0;

    // No idling on either side while set.
    logic calm = 1'b0;

    int     errors       = 0;
    int     cycle_count  = 0;
    int     n_requests   = 0;
    int     n_results    = 0;
    int     n_faults     = 0;
    int     n_gains      = 0;
    code_t  last_code [CHANNELS];

    circular_angle_smoothing_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .channel      (channel),
        .raw_code     (raw_code),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .channel_out  (channel_out),
        .angle_out    (angle_out),
        .fault        (fault)
    );

    always #5 clk = ~clk;

    // Move the stored angle toward the fresh one along the shorter arc,
    // scaled by the gain with round-half-away rounding, and wrap on a turn.
    function automatic angle_t shortest_path_step(input angle_t stored, input angle_t fresh,
                                                  input gain_t g);
        longint delta;
        longint mag;
        longint stp;
        longint sum;
        delta = longint'(fresh) - longint'(stored);
        if (delta > HalfTurn)
            delta -= FullTurn;
        if (delta < -HalfTurn)
            delta += FullTurn;
        mag = (delta < 0) ? -delta : delta;
        stp = (mag * longint'(g) + 32768) >>> 16;
        sum = (delta < 0) ? longint'(stored) - stp : longint'(stored) + stp;
        return angle_t'(sum);
    endfunction

    // Apply one accepted request to the filter copy and return what the
    // block must report for it.
    function automatic filtered_reading_t filter_predict(input chan_t ch, input code_t code);
        filtered_reading_t r;
        angle_t fresh;
        gain_t  g;
        r.chan  = ch;
        r.angle = '0;
        r.fault = 1'b1;
        if (32'(ch) < CHANNELS) begin
            if (code > CodeMax) begin
                // read failure: flag it, leave the filter alone
                model_fault[ch] = 1'b1;
                r.angle = model_angle[ch];
            end else begin
                model_fault[ch] = 1'b0;
                fresh = angle_t'(code) << FRACTION_BITS;
                g = (model_gain > GainOne) ? GainOne : model_gain;
                if (!model_seeded[ch]) begin
                    model_angle[ch]  = fresh;
                    model_seeded[ch] = 1'b1;
                end else begin
                    model_angle[ch] = shortest_path_step(model_angle[ch], fresh, g);
                end
                r.angle = model_angle[ch];
                r.fault = 1'b0;
            end
        end
        return r;
    endfunction

    // Receiver: stall at random, except during the calm stretch.
    always @(negedge clk)
        result_stall <= !calm && ($urandom_range(99) < IdlePct);

    // Watchdog: end the run if the block stops making progress.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("[%0t] timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_readings.size());
            $display("status: fail");
            $finish;
        end
    end

    // Monitor: track gain writes, predict each accepted request and check
    // each accepted result against the oldest prediction. All of it samples
    // at the rising edge, where the driven inputs have long settled.
    always @(posedge clk) begin
        filtered_reading_t pred;
        filtered_reading_t want;
        if (rst_n) begin
            if (cfg_we)
                model_gain = cfg_wdata;
            if (sample_valid && !sample_stall) begin
                pred = filter_predict(channel, raw_code);
                if (row_typed)
                    pred = '{channel, row_angle, row_fault};
                pending_readings.push_back(pred);
                n_requests++;
            end
            if (result_valid && !result_stall) begin
                n_results++;
                if (fault)
                    n_faults++;
                if (pending_readings.size() == 0) begin
                    $display("[%0t] unexpected result: ch %0d angle %h fault %0d",
                             $time, channel_out, angle_out, fault);
                    errors++;
                end else begin
                    want = pending_readings.pop_front();
                    if (channel_out !== want.chan) begin
                        $display("[%0t] channel_out mismatch: expected %0d actual %0d",
                                 $time, want.chan, channel_out);
                        errors++;
                    end
                    if (angle_out !== want.angle) begin
                        $display("[%0t] angle_out mismatch ch %0d: expected %h actual %h",
                                 $time, want.chan, want.angle, angle_out);
                        errors++;
                    end
                    if (fault !== want.fault) begin
                        $display("[%0t] fault mismatch ch %0d: expected %0d actual %0d",
                                 $time, want.chan, want.fault, fault);
                        errors++;
                    end
                end
            end
        end
    end

    // Drive one request. Called at a falling edge; returns at the falling
    // edge after acceptance so the next request can follow without a gap.
    task automatic send_sample(input chan_t ch, input code_t code, input logic typed,
                               input angle_t angle, input logic flt);
        while (!calm && ($urandom_range(99) < IdlePct)) begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        channel      <= ch;
        raw_code     <= code;
        row_typed    = typed;
        row_angle    = angle;
        row_fault    = flt;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold off requests until every result is back, then leave the pipeline
    // idle before returning; write_gain calls this before each gain write.
    task automatic drain_idle();
        sample_valid <= 1'b0;
        @(negedge clk);
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (DrainTail) @(negedge clk);
    endtask

    task automatic write_gain(input gain_t value);
        drain_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        n_gains++;
    endtask

    // Pick a code: mostly well-formed readings near the channel's last code
    // (small steps, wrapping across zero), some anywhere, some failures.
    function automatic code_t pick_code(input chan_t ch);
        int    roll;
        code_t c;
        roll = $urandom_range(99);
        if (roll < 40)
            c = code_t'((last_code[ch] + code_t'($urandom_range(64)) - 16'd32) & CodeMax);
        else if (roll < 65)
            c = code_t'($urandom_range(4095));
        else if (roll < 75)
            c = ($urandom_range(1)) ? code_t'($urandom_range(15))
                                    : code_t'($urandom_range(4095, 4080));
        else if (roll < 80)
            c = code_t'(($urandom_range(2047) + 2048 + last_code[ch]) & CodeMax);
        else if (roll < 90)
            c = code_t'($urandom_range(65535, 4096));
        else
            c = code_t'($urandom_range(65535));
        return c;
    endfunction

    initial begin
        gain_t phase_gain [6];
        chan_t ch;
        code_t code;
        int    per_phase;

        for (int i = 0; i < CHANNELS; i++) begin
            model_angle[i]  = '0;
            model_seeded[i] = 1'b0;
            model_fault[i]  = 1'b0;
            last_code[i]    = '0;
        end
        model_gain = GainReset;

        // Hold reset, then release it at a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed script.
        foreach (script[i]) begin
            if (script[i].kind == ROW_GAIN)
                write_gain(gain_t'(script[i].value));
            else
                send_sample(chan_t'(script[i].chan), code_t'(script[i].value),
                            script[i].typed, angle_t'(script[i].exp_angle),
                            script[i].exp_fault);
        end
        row_typed = 1'b0;

        // Random part: one phase per gain setting, extremes among them.
        phase_gain[0] = gain_t'($urandom_range(65535, 1));
        phase_gain[1] = gain_t'(1);
        phase_gain[2] = gain_t'($urandom_range(131071, 65537));
        phase_gain[3] = gain_t'(65535);
        phase_gain[4] = gain_t'($urandom_range(65536));
        phase_gain[5] = GainReset;
        per_phase = 67;

        foreach (phase_gain[p]) begin
            write_gain(phase_gain[p]);
            // second phase runs with no idling on either side
            calm = (p == 1);
            for (int k = 0; k < per_phase; k++) begin
                // pause once mid-run until every result has come back
                if (p == 3 && k == per_phase / 2)
                    drain_idle();
                ch   = chan_t'($urandom_range(CHANNELS - 1));
                code = pick_code(ch);
                if (code <= CodeMax)
                    last_code[ch] = code;
                send_sample(ch, code, 1'b0, '0, 1'b0);
            end
            calm = 1'b0;
        end

        // Drain the remaining results, then keep watching the idle outputs for
        // anything extra.
        sample_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DrainTail) @(posedge clk);

        $display("covered %0d requests and %0d results (%0d faults) over %0d gain writes",
                 n_requests, n_results, n_faults, n_gains);
        $display("gains ranged from zero through unity to saturated, %0d errors seen", errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/cas_pkg.sv
rtl/cas_store.sv
rtl/cas_update.sv
rtl/circular_angle_smoothing_filter.sv
sim/tb_top.sv
